/* sv/tkt_pkg.sv */
// ----------------------------------------------------------------------------
// tkt_pkg: shared types and constants of the two-value key table
// Command and status codes, request and result words, default sizes.
// ----------------------------------------------------------------------------
package tkt_pkg;

    localparam int          TKT_DEPTH       = 64;
    localparam int          TKT_LIMIT_W     = 7;
    localparam int          TKT_DATA_W      = 32;
    localparam logic [6:0]  TKT_LIMIT_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                           cmd;
        logic signed [TKT_DATA_W-1:0]   key;
        logic signed [TKT_DATA_W-1:0]   value;
    } req_t;

    typedef struct packed {
        status_t                        status;
        logic                           first_found;
        logic signed [TKT_DATA_W-1:0]   first_value;
        logic                           second_found;
        logic signed [TKT_DATA_W-1:0]   second_value;
        logic [TKT_LIMIT_W-1:0]         fill_count;
        logic                           is_empty;
        logic                           is_full;
    } res_t;

endpackage

/* sv/tkt_ifs.sv */
// ----------------------------------------------------------------------------
// tkt_ifs: request and response channels of the two-value key table
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tkt_req_if;
    import tkt_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [1:0]                     cmd;
    logic signed [TKT_DATA_W-1:0]   key;
    logic signed [TKT_DATA_W-1:0]   value;

    modport source (output valid, output cmd, output key, output value, input ready);
    modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface tkt_rsp_if;
    import tkt_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic                           first_found;
    logic signed [TKT_DATA_W-1:0]   first_value;
    logic                           second_found;
    logic signed [TKT_DATA_W-1:0]   second_value;
    logic [TKT_LIMIT_W-1:0]         fill_count;
    logic                           is_empty;
    logic                           is_full;

    modport source (
        output valid, output status, output first_found, output first_value,
        output second_found, output second_value, output fill_count,
        output is_empty, output is_full, input ready
    );
    modport sink (
        input valid, input status, input first_found, input first_value,
        input second_found, input second_value, input fill_count,
        input is_empty, input is_full, output ready
    );
endinterface

/* sv/two_value_key_table_unit.sv */
// ----------------------------------------------------------------------------
// two_value_key_table_unit: table of key/value pairs, two values per key
// Add, search and remove over up to DEPTH pairs held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word (cmd, key, value); rsp returns one result
//   word per command, in order. cfg_we/cfg_wdata set the capacity limit;
//   write it only while no command is outstanding.
//   A search, a remove or an add below the limit scans the stored pairs
//   through a single memory read port, one entry a cycle, stopping early
//   once the answer is settled. A remove that hits then reads the last
//   entry and moves it into the hole. A full-table add or unused command
//   skips the scan and goes straight to its result.
//   After a result moves into the output register, the next command is taken
//   at once, even while that result still waits on rsp.ready; a stalled
//   receiver holds the result and the engine waits with its next one.
//   Reset empties the table (fill count zero), sets the limit to 64 and drops
//   any held result. Memory contents are not cleared: only live entries are
//   ever read.
// ----------------------------------------------------------------------------
module two_value_key_table_unit #(
    parameter int DEPTH = tkt_pkg::TKT_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tkt_req_if.sink                         req,
    tkt_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [tkt_pkg::TKT_LIMIT_W-1:0] cfg_wdata
);
    import tkt_pkg::*;

    logic [TKT_LIMIT_W-1:0] limit_reg;
    logic                   out_valid_reg;
    res_t                   out_data_reg;

    req_t                   eng_req;
    res_t                   eng_res;
    logic                   eng_res_valid;
    logic                   res_take;

    assign eng_req.cmd   = cmd_t'(req.cmd);
    assign eng_req.key   = req.key;
    assign eng_req.value = req.value;

    assign res_take = !out_valid_reg || rsp.ready;

    tkt_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req       (eng_req),
        .cap_limit (limit_reg),
        .res_valid (eng_res_valid),
        .res_take  (res_take),
        .res       (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= TKT_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (res_take)
            begin
                out_valid_reg <= eng_res_valid;
            end
        end
    end

    // hold the word while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (res_take && eng_res_valid)
        begin
            out_data_reg <= eng_res;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_data_reg.status;
    assign rsp.first_found  = out_data_reg.first_found;
    assign rsp.first_value  = out_data_reg.first_value;
    assign rsp.second_found = out_data_reg.second_found;
    assign rsp.second_value = out_data_reg.second_value;
    assign rsp.fill_count   = out_data_reg.fill_count;
    assign rsp.is_empty     = out_data_reg.is_empty;
    assign rsp.is_full      = out_data_reg.is_full;

    a_found_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_DONE) |-> !rsp.first_found && !rsp.second_found)
        else $error("found flag set on a refused command");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.second_found |-> rsp.first_found)
        else $error("second value found without a first");

    a_full_status_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_FULL) |-> rsp.is_full && !rsp.is_empty)
        else $error("table-full status without full flag");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        eng_res_valid && !res_take |=> !req.ready)
        else $error("command taken while a result is stuck in the engine");

endmodule

/* sv/tkt_engine.sv */
// ----------------------------------------------------------------------------
// tkt_engine: pair store and scan sequencer
// Holds the key/value pairs in one synchronous memory, scans it one entry
// a cycle through a registered read port, and appends or back-fills holes.
// ----------------------------------------------------------------------------
module tkt_engine #(
    parameter int DEPTH = tkt_pkg::TKT_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  tkt_pkg::req_t                   req,
    input  logic [tkt_pkg::TKT_LIMIT_W-1:0] cap_limit,
    output logic                            res_valid,
    input  logic                            res_take,
    output tkt_pkg::res_t                   res
);
    import tkt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > TKT_LIMIT_W) ? CW : TKT_LIMIT_W;
    localparam int MW = 2 * TKT_DATA_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_RDLAST = 5'b00100,
        S_MOVE   = 5'b01000,
        S_RESP   = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [TKT_DATA_W-1:0]  key_reg, key_next;
    logic [TKT_DATA_W-1:0]  val_reg, val_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic [AW-1:0]          pidx_reg, pidx_next;
    logic [1:0]             hits_reg, hits_next;
    logic [TKT_DATA_W-1:0]  v0_reg, v0_next;
    logic [TKT_DATA_W-1:0]  v1_reg, v1_next;
    logic [AW-1:0]          hole_reg, hole_next;
    status_t                status_reg, status_next;
    logic [CW-1:0]          count_reg, count_next;

    logic [MW-1:0]          mem [DEPTH];
    logic [MW-1:0]          dout_reg;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [MW-1:0]          wr_data;

    logic [LW-1:0]          lim_w;
    logic                   at_limit;
    logic [CW-1:0]          last_idx;
    logic                   issue;
    logic                   key_hit;
    logic                   pair_hit;
    logic                   term;
    logic                   is_search;

    // effective limit: zero acts as one, anything above the depth as the depth
    always_comb
    begin
        lim_w = LW'(cap_limit);
        if (lim_w == '0)
        begin
            lim_w = LW'(1);
        end
        if (lim_w > LW'(DEPTH))
        begin
            lim_w = LW'(DEPTH);
        end
    end

    assign at_limit = (LW'(count_reg) >= lim_w);
    assign last_idx = count_reg - CW'(1);
    assign issue    = (idx_reg < count_reg);
    assign key_hit  = pend_reg && (dout_reg[MW-1:TKT_DATA_W] == key_reg);
    assign pair_hit = key_hit && (dout_reg[TKT_DATA_W-1:0] == val_reg);
    assign term     = (cmd_reg == CMD_REMOVE) ? pair_hit : (key_hit && (hits_reg == 2'd1));

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        hits_next   = hits_reg;
        v0_next     = v0_reg;
        v1_next     = v1_reg;
        hole_next   = hole_reg;
        status_next = status_reg;
        count_next  = count_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = count_reg[AW-1:0];
        wr_data     = {key_reg, val_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next    = req.cmd;
                    key_next    = req.key;
                    val_next    = req.value;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    hits_next   = 2'd0;
                    v0_next     = '0;
                    v1_next     = '0;
                    status_next = ST_DONE;
                    if (req.cmd == CMD_ADD && at_limit)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_RESP;
                    end
                    else if (req.cmd == CMD_NOP)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (key_hit && cmd_reg != CMD_REMOVE)
                begin
                    hits_next = hits_reg + 2'd1;
                    if (hits_reg == 2'd0)
                    begin
                        v0_next = dout_reg[TKT_DATA_W-1:0];
                    end
                    else
                    begin
                        v1_next = dout_reg[TKT_DATA_W-1:0];
                    end
                end
                // keep one read in flight ahead of the compare
                rd_en     = issue && !term;
                pend_next = rd_en;
                pidx_next = idx_reg[AW-1:0];
                if (rd_en)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (term || !issue)
                begin
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            if (term)
                            begin
                                status_next = ST_DUP;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            state_next = S_RESP;
                        end
                        CMD_REMOVE:
                        begin
                            if (term)
                            begin
                                hole_next  = pidx_reg;
                                state_next = S_RDLAST;
                            end
                            else
                            begin
                                status_next = ST_MISS;
                                state_next  = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_RDLAST:
            begin
                rd_en      = 1'b1;
                rd_addr    = last_idx[AW-1:0];
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                // drop the last entry into the hole
                wr_en       = 1'b1;
                wr_addr     = hole_reg;
                wr_data     = dout_reg;
                count_next  = last_idx;
                status_next = ST_DONE;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            idx_reg   <= '0;
            hits_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
            hits_reg  <= hits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        pidx_reg   <= pidx_next;
        v0_reg     <= v0_next;
        v1_reg     <= v1_next;
        hole_reg   <= hole_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            dout_reg <= mem[rd_addr];
        end
    end

    assign is_search = (cmd_reg == CMD_SEARCH);
    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);

    always_comb
    begin
        res.status       = status_reg;
        res.first_found  = is_search && (hits_reg != 2'd0);
        res.first_value  = is_search ? v0_reg : '0;
        res.second_found = is_search && (hits_reg == 2'd2);
        res.second_value = is_search ? v1_reg : '0;
        res.fill_count   = TKT_LIMIT_W'(count_reg);
        res.is_empty     = (count_reg == '0);
        res.is_full      = at_limit;
    end

endmodule
